// ===== src/mik_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics: shared types and constants
// Fixed-point widths, angle constants, CORDIC arctangent table and the
// words that move between the pipeline cells.
// ----------------------------------------------------------------------------
package mik_pkg;

    localparam int VEL_W   = 32;               // Q16.16 velocities
    localparam int HEAD_W  = 16;               // Q4.12 heading
    localparam int ARM_W   = 24;               // Q8.16 lever arm
    localparam int ANG_W   = 35;               // Q30 angle before folding
    localparam int Z_W     = 32;               // Q30 residual angle in the cells
    localparam int NEG_W   = VEL_W + 1;        // velocity after optional negation
    localparam int GAIN_W  = 31;
    localparam int GPROD_W = NEG_W + GAIN_W;   // 64
    localparam int XY_W    = 42;               // Q16.24 rotator datapath
    localparam int PROD_W  = VEL_W + ARM_W + 1; // yaw rate times lever arm
    localparam int W_W     = PROD_W - 16;      // rotation term, Q16.16
    localparam int ROT_W   = XY_W - 8;         // rotated velocity, Q16.16
    localparam int SUM_W   = W_W + 2;

    localparam int ATAN_COUNT = 24;
    localparam int ATAN_IDX_W = $clog2(ATAN_COUNT);
    localparam int GUARD_BITS = 8;
    localparam int HEAD_SHIFT = 18;

    localparam logic signed [ANG_W-1:0]   PI_Q30      = 35'sd3373259426;
    localparam logic signed [ANG_W-1:0]   HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ANG_W-1:0]   TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [GAIN_W-1:0]  GAIN_Q30    = 31'sd652032874;
    localparam logic signed [GPROD_W-1:0] GAIN_RND    = 64'sd2097152;
    localparam logic signed [PROD_W-1:0]  PROD_RND    = 57'sd32768;
    localparam logic signed [XY_W-1:0]    GUARD_RND   = 42'sd128;

    localparam logic signed [VEL_W-1:0] WHEEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VEL_W-1:0] WHEEL_MIN = 32'sh8000_0000;

    // configuration register indexes
    localparam logic [0:0] CFG_ROLLER_LAYOUT = 1'b0;
    localparam logic [0:0] CFG_LEVER_ARM     = 1'b1;

    // roller layout codes
    localparam logic LAYOUT_O = 1'b0;
    localparam logic LAYOUT_X = 1'b1;

    localparam logic [ARM_W-1:0] LEVER_ARM_RESET = 24'd65536;

    typedef struct packed {
        logic signed [NEG_W-1:0]  x0;
        logic signed [NEG_W-1:0]  y0;
        logic signed [Z_W-1:0]    z;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic signed [PROD_W-1:0] yaw_prod;
        logic                     frame_global;
    } prep_word_t;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [W_W-1:0]   w;
        logic                    frame_global;
    } rot_word_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [Z_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        unique case (idx)
            5'd0:    a = 32'sd843314856;
            5'd1:    a = 32'sd497837829;
            5'd2:    a = 32'sd263043836;
            5'd3:    a = 32'sd133525158;
            5'd4:    a = 32'sd67021686;
            5'd5:    a = 32'sd33543515;
            5'd6:    a = 32'sd16775850;
            5'd7:    a = 32'sd8388437;
            5'd8:    a = 32'sd4194282;
            5'd9:    a = 32'sd2097149;
            5'd10:   a = 32'sd1048575;
            5'd11:   a = 32'sd524287;
            5'd12:   a = 32'sd262143;
            5'd13:   a = 32'sd131071;
            5'd14:   a = 32'sd65535;
            5'd15:   a = 32'sd32767;
            5'd16:   a = 32'sd16383;
            5'd17:   a = 32'sd8191;
            5'd18:   a = 32'sd4095;
            5'd19:   a = 32'sd2047;
            5'd20:   a = 32'sd1023;
            5'd21:   a = 32'sd511;
            5'd22:   a = 32'sd255;
            5'd23:   a = 32'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== src/mecanum_inverse_kinematics_unit.sv =====
// An accepted word passes the prep, gain, CORDIC, select and output registers in turn.
// Throughput: one word per cycle, every cell taking a new one, while out_stall is low.
// Each cell holds its word while the next one is full, so bubbles close up and the
// input keeps taking words while a finished result waits in the output register.
// Reset clears all valid flags and loads roller_layout = O and lever_arm = 1.0 m.
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics unit
// Chassis command to four wheel speeds, with an optional world-to-body
// rotation through a chain of CORDIC cells.
// ----------------------------------------------------------------------------
module mecanum_inverse_kinematics_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [mik_pkg::ARM_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [mik_pkg::VEL_W-1:0]  vel_x,
    input  logic signed [mik_pkg::VEL_W-1:0]  vel_y,
    input  logic signed [mik_pkg::VEL_W-1:0]  yaw_rate,
    input  logic signed [mik_pkg::HEAD_W-1:0] heading,
    input  logic                             frame_global,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [mik_pkg::VEL_W-1:0]  wheel_front_left,
    output logic signed [mik_pkg::VEL_W-1:0]  wheel_front_right,
    output logic signed [mik_pkg::VEL_W-1:0]  wheel_rear_left,
    output logic signed [mik_pkg::VEL_W-1:0]  wheel_rear_right,
    output logic                             clipped
);
    import mik_pkg::*;

    localparam int CELL_COUNT = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;

    logic             roller_layout_reg;
    logic [ARM_W-1:0] lever_arm_reg;

    logic       prep_ready;
    logic       prep_valid;
    prep_word_t prep_word;
    logic       gain_ready;

    logic      cell_valid [CELL_COUNT+1];
    logic      cell_ready [CELL_COUNT+1];
    rot_word_t cell_word  [CELL_COUNT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roller_layout_reg <= LAYOUT_O;
            lever_arm_reg     <= LEVER_ARM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROLLER_LAYOUT: roller_layout_reg <= cfg_data[0];
                CFG_LEVER_ARM:     lever_arm_reg     <= cfg_data;
            endcase
        end
    end

    assign in_stall = !prep_ready;

    mik_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .valid_up     (in_valid),
        .ready_up     (prep_ready),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .yaw_rate     (yaw_rate),
        .heading      (heading),
        .frame_global (frame_global),
        .lever_arm    (lever_arm_reg),
        .valid_dn     (prep_valid),
        .ready_dn     (gain_ready),
        .word_dn      (prep_word)
    );

    mik_gain u_gain (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_up (prep_valid),
        .ready_up (gain_ready),
        .word_up  (prep_word),
        .valid_dn (cell_valid[0]),
        .ready_dn (cell_ready[0]),
        .word_dn  (cell_word[0])
    );

    for (genvar k = 0; k < CELL_COUNT; k++)
    begin : g_cell
        mik_cordic_cell #(
            .SHIFT (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_up (cell_valid[k]),
            .ready_up (cell_ready[k]),
            .word_up  (cell_word[k]),
            .valid_dn (cell_valid[k+1]),
            .ready_dn (cell_ready[k+1]),
            .word_dn  (cell_word[k+1])
        );
    end

    mik_mix u_mix (
        .clk               (clk),
        .rst_n             (rst_n),
        .valid_up          (cell_valid[CELL_COUNT]),
        .ready_up          (cell_ready[CELL_COUNT]),
        .word_up           (cell_word[CELL_COUNT]),
        .roller_layout     (roller_layout_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .wheel_front_left  (wheel_front_left),
        .wheel_front_right (wheel_front_right),
        .wheel_rear_left   (wheel_rear_left),
        .wheel_rear_right  (wheel_rear_right),
        .clipped           (clipped)
    );

endmodule

// ===== src/mik_prep.sv =====
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics: input cell
// Reduces minus the heading into [-pi/2, pi/2] with a half-turn fold,
// negates the vector on a fold and forms yaw rate times lever arm.
// ----------------------------------------------------------------------------
module mik_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_up,
    output logic                                 ready_up,
    input  logic signed [mik_pkg::VEL_W-1:0]     vel_x,
    input  logic signed [mik_pkg::VEL_W-1:0]     vel_y,
    input  logic signed [mik_pkg::VEL_W-1:0]     yaw_rate,
    input  logic signed [mik_pkg::HEAD_W-1:0]    heading,
    input  logic                                 frame_global,
    input  logic        [mik_pkg::ARM_W-1:0]     lever_arm,
    output logic                                 valid_dn,
    input  logic                                 ready_dn,
    output mik_pkg::prep_word_t                  word_dn
);
    import mik_pkg::*;

    logic              valid_reg;
    prep_word_t        word_reg;
    prep_word_t        word_next;
    logic signed [ANG_W-1:0] ang_raw;
    logic signed [ANG_W-1:0] ang_wrap;
    logic signed [ANG_W-1:0] ang_fold;
    logic                    flip;
    logic signed [NEG_W-1:0] vx_ext;
    logic signed [NEG_W-1:0] vy_ext;
    logic signed [ARM_W:0]   arm_s;

    assign ready_up = !valid_reg || ready_dn;
    assign valid_dn = valid_reg;
    assign word_dn  = word_reg;

    always_comb
    begin
        ang_raw = -(ANG_W'(heading) <<< HEAD_SHIFT);

        // one wrap is enough for the heading range
        if (ang_raw > PI_Q30)
        begin
            ang_wrap = ang_raw - TWO_PI_Q30;
        end
        else if (ang_raw < -PI_Q30)
        begin
            ang_wrap = ang_raw + TWO_PI_Q30;
        end
        else
        begin
            ang_wrap = ang_raw;
        end

        if (ang_wrap > HALF_PI_Q30)
        begin
            ang_fold = ang_wrap - PI_Q30;
            flip     = 1'b1;
        end
        else if (ang_wrap < -HALF_PI_Q30)
        begin
            ang_fold = ang_wrap + PI_Q30;
            flip     = 1'b1;
        end
        else
        begin
            ang_fold = ang_wrap;
            flip     = 1'b0;
        end

        vx_ext = NEG_W'(vel_x);
        vy_ext = NEG_W'(vel_y);
        arm_s  = $signed({1'b0, lever_arm});

        word_next.x0           = flip ? -vx_ext : vx_ext;
        word_next.y0           = flip ? -vy_ext : vy_ext;
        word_next.z            = Z_W'(ang_fold);
        word_next.vel_x        = vel_x;
        word_next.vel_y        = vel_y;
        word_next.yaw_prod     = yaw_rate * arm_s;
        word_next.frame_global = frame_global;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/mik_gain.sv =====
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics: gain cell
// Prescales the vector by the CORDIC gain into Q16.24 and rounds the
// rotation term to Q16.16.
// ----------------------------------------------------------------------------
module mik_gain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_up,
    output logic                ready_up,
    input  mik_pkg::prep_word_t word_up,
    output logic                valid_dn,
    input  logic                ready_dn,
    output mik_pkg::rot_word_t  word_dn
);
    import mik_pkg::*;

    logic                      valid_reg;
    rot_word_t                 word_reg;
    rot_word_t                 word_next;
    logic signed [GPROD_W-1:0] gx;
    logic signed [GPROD_W-1:0] gy;
    logic signed [PROD_W-1:0]  w_full;

    assign ready_up = !valid_reg || ready_dn;
    assign valid_dn = valid_reg;
    assign word_dn  = word_reg;

    always_comb
    begin
        gx     = word_up.x0 * GAIN_Q30;
        gy     = word_up.y0 * GAIN_Q30;
        w_full = (word_up.yaw_prod + PROD_RND) >>> 16;

        word_next.x            = XY_W'((gx + GAIN_RND) >>> 22);
        word_next.y            = XY_W'((gy + GAIN_RND) >>> 22);
        word_next.z            = word_up.z;
        word_next.vel_x        = word_up.vel_x;
        word_next.vel_y        = word_up.vel_y;
        word_next.w            = W_W'(w_full);
        word_next.frame_global = word_up.frame_global;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/mik_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics: CORDIC cell
// One micro-rotation by atan(2^-SHIFT), steered by the sign of the
// residual angle.
// ----------------------------------------------------------------------------
module mik_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_up,
    output logic               ready_up,
    input  mik_pkg::rot_word_t word_up,
    output logic               valid_dn,
    input  logic               ready_dn,
    output mik_pkg::rot_word_t word_dn
);
    import mik_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_q30(ATAN_IDX_W'(SHIFT));

    logic                   valid_reg;
    rot_word_t              word_reg;
    rot_word_t              word_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign ready_up = !valid_reg || ready_dn;
    assign valid_dn = valid_reg;
    assign word_dn  = word_reg;

    always_comb
    begin
        dx        = word_up.y >>> SHIFT;
        dy        = word_up.x >>> SHIFT;
        word_next = word_up;
        if (!word_up.z[Z_W-1])
        begin
            word_next.x = word_up.x - dx;
            word_next.y = word_up.y + dy;
            word_next.z = word_up.z - ATAN;
        end
        else
        begin
            word_next.x = word_up.x + dx;
            word_next.y = word_up.y - dy;
            word_next.z = word_up.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_up;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_up)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/mik_mix.sv =====
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics: wheel mixer
// Picks rotated or body-frame velocity, mixes four wheel speeds by the
// roller layout and saturates them into the output register.
// ----------------------------------------------------------------------------
module mik_mix (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             valid_up,
    output logic                             ready_up,
    input  mik_pkg::rot_word_t               word_up,
    input  logic                             roller_layout,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [mik_pkg::VEL_W-1:0] wheel_front_left,
    output logic signed [mik_pkg::VEL_W-1:0] wheel_front_right,
    output logic signed [mik_pkg::VEL_W-1:0] wheel_rear_left,
    output logic signed [mik_pkg::VEL_W-1:0] wheel_rear_right,
    output logic                             clipped
);
    import mik_pkg::*;

    typedef struct packed {
        logic signed [ROT_W-1:0] vx;
        logic signed [ROT_W-1:0] vy;
        logic signed [W_W-1:0]   w;
    } mix_word_t;

    logic                    sel_valid_reg;
    mix_word_t               sel_reg;
    mix_word_t               sel_next;
    logic                    sel_ready;
    logic                    out_ready;
    logic                    out_valid_reg;
    logic signed [VEL_W-1:0] wheel_reg  [4];
    logic signed [VEL_W-1:0] wheel_next [4];
    logic                    clip_reg;
    logic                    clip_next;
    logic signed [SUM_W-1:0] sum [4];
    logic signed [SUM_W-1:0] vx_s;
    logic signed [SUM_W-1:0] vy_s;
    logic signed [SUM_W-1:0] w_s;
    logic [3:0]              hit;

    assign out_ready = !out_valid_reg || !out_stall;
    assign sel_ready = !sel_valid_reg || out_ready;
    assign ready_up  = sel_ready;

    // select stage: drop the guard bits of the rotator, or pass the body-frame velocity
    always_comb
    begin
        if (word_up.frame_global)
        begin
            sel_next.vx = ROT_W'((word_up.x + GUARD_RND) >>> GUARD_BITS);
            sel_next.vy = ROT_W'((word_up.y + GUARD_RND) >>> GUARD_BITS);
        end
        else
        begin
            sel_next.vx = ROT_W'(word_up.vel_x);
            sel_next.vy = ROT_W'(word_up.vel_y);
        end
        sel_next.w = word_up.w;
    end

    always_comb
    begin
        vx_s = SUM_W'(sel_reg.vx);
        vy_s = SUM_W'(sel_reg.vy);
        w_s  = SUM_W'(sel_reg.w);
        unique case (roller_layout)
            LAYOUT_O:
            begin
                sum[0] = vy_s - vx_s + w_s;
                sum[1] = vy_s + vx_s - w_s;
                sum[2] = vy_s - vx_s - w_s;
                sum[3] = vy_s + vx_s + w_s;
            end
            LAYOUT_X:
            begin
                sum[0] = vx_s - vy_s - w_s;
                sum[1] = vx_s + vy_s + w_s;
                sum[2] = vx_s + vy_s - w_s;
                sum[3] = vx_s - vy_s + w_s;
            end
        endcase
        for (int k = 0; k < 4; k++)
        begin
            if (sum[k] > SUM_W'(WHEEL_MAX))
            begin
                wheel_next[k] = WHEEL_MAX;
                hit[k]        = 1'b1;
            end
            else if (sum[k] < SUM_W'(WHEEL_MIN))
            begin
                wheel_next[k] = WHEEL_MIN;
                hit[k]        = 1'b1;
            end
            else
            begin
                wheel_next[k] = VEL_W'(sum[k]);
                hit[k]        = 1'b0;
            end
        end
        clip_next = |hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sel_ready)
            begin
                sel_valid_reg <= valid_up;
            end
            if (out_ready)
            begin
                out_valid_reg <= sel_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_ready && valid_up)
        begin
            sel_reg <= sel_next;
        end
        if (out_ready && sel_valid_reg)
        begin
            wheel_reg <= wheel_next;
            clip_reg  <= clip_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign wheel_front_left  = wheel_reg[0];
    assign wheel_front_right = wheel_reg[1];
    assign wheel_rear_left   = wheel_reg[2];
    assign wheel_rear_right  = wheel_reg[3];
    assign clipped           = clip_reg;

endmodule

// ===== src/mik_checker.sv =====
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics: port checker
// Watches the top-level ports for output hold, back-pressure and the
// meaning of the saturation flag.
// ----------------------------------------------------------------------------
module mik_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [mik_pkg::VEL_W-1:0] wheel_front_left,
    input logic signed [mik_pkg::VEL_W-1:0] wheel_front_right,
    input logic signed [mik_pkg::VEL_W-1:0] wheel_rear_left,
    input logic signed [mik_pkg::VEL_W-1:0] wheel_rear_right,
    input logic                             clipped
);
    import mik_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(wheel_front_left) && $stable(wheel_front_right)
            && $stable(wheel_rear_left) && $stable(wheel_rear_right) && $stable(clipped))
        else $error("output word changed while stalled");

    // with an empty output register the whole chain can move
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

    // a clipped word has at least one wheel at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (wheel_front_left == WHEEL_MAX) || (wheel_front_left == WHEEL_MIN)
            || (wheel_front_right == WHEEL_MAX) || (wheel_front_right == WHEEL_MIN)
            || (wheel_rear_left == WHEEL_MAX) || (wheel_rear_left == WHEEL_MIN)
            || (wheel_rear_right == WHEEL_MAX) || (wheel_rear_right == WHEEL_MIN))
        else $error("clipped set with no wheel at a rail");

endmodule

bind mecanum_inverse_kinematics_unit mik_checker u_mik_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .wheel_front_left  (wheel_front_left),
    .wheel_front_right (wheel_front_right),
    .wheel_rear_left   (wheel_rear_left),
    .wheel_rear_right  (wheel_rear_right),
    .clipped           (clipped)
);

// ===== tb/mecanum_inverse_kinematics_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics unit testbench
// Drives chassis commands through the unit under bursty input traffic and a
// stalling output, predicts the four saturated wheel speeds of each word with
// a bit-exact fixed-point rotation and mixer, and checks results in order.
// ----------------------------------------------------------------------------
module mecanum_inverse_kinematics_unit_test;

    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_WORDS   = 100;

    typedef struct {
        logic signed [mik_pkg::VEL_W-1:0]  vel_x;
        logic signed [mik_pkg::VEL_W-1:0]  vel_y;
        logic signed [mik_pkg::VEL_W-1:0]  yaw_rate;
        logic signed [mik_pkg::HEAD_W-1:0] heading;
        logic                              frame_global;
    } chassis_cmd_t;

    typedef struct {
        logic signed [mik_pkg::VEL_W-1:0] wheel [4];
        logic                             clipped;
    } wheel_set_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    class wheel_speed_scoreboard;
        logic                      layout;
        logic [mik_pkg::ARM_W-1:0] arm;
        wheel_set_t                pending_speeds [$];
        int                        fails;

        function new();
            layout = mik_pkg::LAYOUT_O;
            arm    = mik_pkg::LEVER_ARM_RESET;
            fails  = 0;
        endfunction

        function longint atan_step(int i);
            case (i)
                0:       return 64'sd843314856;
                1:       return 64'sd497837829;
                2:       return 64'sd263043836;
                3:       return 64'sd133525158;
                4:       return 64'sd67021686;
                5:       return 64'sd33543515;
                6:       return 64'sd16775850;
                7:       return 64'sd8388437;
                8:       return 64'sd4194282;
                9:       return 64'sd2097149;
                10:      return 64'sd1048575;
                11:      return 64'sd524287;
                12:      return 64'sd262143;
                13:      return 64'sd131071;
                14:      return 64'sd65535;
                15:      return 64'sd32767;
                16:      return 64'sd16383;
                17:      return 64'sd8191;
                18:      return 64'sd4095;
                19:      return 64'sd2047;
                20:      return 64'sd1023;
                21:      return 64'sd511;
                22:      return 64'sd255;
                default: return 64'sd127;
            endcase
        endfunction

        function wheel_set_t mix_wheels(chassis_cmd_t c);
            longint     vx;
            longint     vy;
            longint     wz;
            longint     t;
            longint     dx;
            longint     dy;
            longint     w;
            longint     s [4];
            int         n;
            wheel_set_t r;
            vx = longint'(c.vel_x);
            vy = longint'(c.vel_y);
            wz = longint'(c.yaw_rate);
            if (c.frame_global)
            begin
                t = -longint'(c.heading) * 64'sd262144;
                while (t > longint'(mik_pkg::PI_Q30))
                    t -= longint'(mik_pkg::TWO_PI_Q30);
                while (t < -longint'(mik_pkg::PI_Q30))
                    t += longint'(mik_pkg::TWO_PI_Q30);
                // fold into the right half plane, negating the vector
                if (t > longint'(mik_pkg::HALF_PI_Q30))
                begin
                    t -= longint'(mik_pkg::PI_Q30);
                    vx = -vx;
                    vy = -vy;
                end
                else if (t < -longint'(mik_pkg::HALF_PI_Q30))
                begin
                    t += longint'(mik_pkg::PI_Q30);
                    vx = -vx;
                    vy = -vy;
                end
                vx = (vx * longint'(mik_pkg::GAIN_Q30) + 64'sd2097152) >>> 22;
                vy = (vy * longint'(mik_pkg::GAIN_Q30) + 64'sd2097152) >>> 22;
                n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
                for (int i = 0; i < n; i++)
                begin
                    dx = vy >>> i;
                    dy = vx >>> i;
                    if (t >= 0)
                    begin
                        vx -= dx;
                        vy += dy;
                        t  -= atan_step(i);
                    end
                    else
                    begin
                        vx += dx;
                        vy -= dy;
                        t  += atan_step(i);
                    end
                end
                vx = (vx + 64'sd128) >>> 8;
                vy = (vy + 64'sd128) >>> 8;
            end
            w = (wz * longint'({40'd0, arm}) + 64'sd32768) >>> 16;
            if (layout == mik_pkg::LAYOUT_O)
            begin
                s[0] = vy - vx + w;
                s[1] = vy + vx - w;
                s[2] = vy - vx - w;
                s[3] = vy + vx + w;
            end
            else
            begin
                s[0] = vx - vy - w;
                s[1] = vx + vy + w;
                s[2] = vx + vy - w;
                s[3] = vx - vy + w;
            end
            r.clipped = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                if (s[k] > 64'sd2147483647)
                begin
                    r.wheel[k] = mik_pkg::WHEEL_MAX;
                    r.clipped  = 1'b1;
                end
                else if (s[k] < -64'sd2147483648)
                begin
                    r.wheel[k] = mik_pkg::WHEEL_MIN;
                    r.clipped  = 1'b1;
                end
                else
                    r.wheel[k] = s[k][31:0];
            end
            return r;
        endfunction

        function void note_word(chassis_cmd_t c);
            pending_speeds.push_back(mix_wheels(c));
        endfunction

        function void check_word(wheel_set_t got);
            wheel_set_t want;
            if (pending_speeds.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected wheel word: fl=%0d fr=%0d rl=%0d rr=%0d clip=%0b",
                             got.wheel[0], got.wheel[1], got.wheel[2], got.wheel[3],
                             got.clipped);
                return;
            end
            want = pending_speeds.pop_front();
            if (got.wheel[0] !== want.wheel[0] || got.wheel[1] !== want.wheel[1] ||
                got.wheel[2] !== want.wheel[2] || got.wheel[3] !== want.wheel[3] ||
                got.clipped !== want.clipped)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("wheel mismatch: expected fl=%0d fr=%0d rl=%0d rr=%0d clip=%0b",
                             want.wheel[0], want.wheel[1], want.wheel[2], want.wheel[3],
                             want.clipped);
                    $display("                got      fl=%0d fr=%0d rl=%0d rr=%0d clip=%0b",
                             got.wheel[0], got.wheel[1], got.wheel[2], got.wheel[3],
                             got.clipped);
                end
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [0:0]                        cfg_index;
    logic [mik_pkg::ARM_W-1:0]         cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [mik_pkg::VEL_W-1:0]  vel_x;
    logic signed [mik_pkg::VEL_W-1:0]  vel_y;
    logic signed [mik_pkg::VEL_W-1:0]  yaw_rate;
    logic signed [mik_pkg::HEAD_W-1:0] heading;
    logic                              frame_global;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [mik_pkg::VEL_W-1:0]  wheel_front_left;
    logic signed [mik_pkg::VEL_W-1:0]  wheel_front_right;
    logic signed [mik_pkg::VEL_W-1:0]  wheel_rear_left;
    logic signed [mik_pkg::VEL_W-1:0]  wheel_rear_right;
    logic                              clipped;

    wheel_speed_scoreboard sb;
    stall_mode_t           stall_mode  = STALL_NONE;
    int                    stall_left  = 0;
    int                    quiet_count = 0;

    mecanum_inverse_kinematics_unit #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .vel_x            (vel_x),
        .vel_y            (vel_y),
        .yaw_rate         (yaw_rate),
        .heading          (heading),
        .frame_global     (frame_global),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .wheel_front_left (wheel_front_left),
        .wheel_front_right(wheel_front_right),
        .wheel_rear_left  (wheel_rear_left),
        .wheel_rear_right (wheel_rear_right),
        .clipped          (clipped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output stall pattern, switching to a new random style when each random run ends
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall = 1'b0;
            STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
            default:     out_stall = ((stall_left % 16) < 6);
        endcase
    end

    // result monitor and watchdog
    always @(posedge clk)
    begin
        wheel_set_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.wheel[0] = wheel_front_left;
                seen.wheel[1] = wheel_front_right;
                seen.wheel[2] = wheel_rear_left;
                seen.wheel[3] = wheel_rear_right;
                seen.clipped  = clipped;
                sb.check_word(seen);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_count = 0;
        else
            quiet_count++;
        if (quiet_count >= STALL_LIMIT)
        begin
            $display("[mecanum_inverse_kinematics_unit] ERROR");
            $finish;
        end
    end

    task automatic send_cmd(input logic signed [31:0] vx, input logic signed [31:0] vy,
                            input logic signed [31:0] wz, input logic signed [15:0] hd,
                            input logic fg);
        chassis_cmd_t c;
        c.vel_x        = vx;
        c.vel_y        = vy;
        c.yaw_rate     = wz;
        c.heading      = hd;
        c.frame_global = fg;
        @(negedge clk);
        in_valid     = 1'b1;
        vel_x        = vx;
        vel_y        = vy;
        yaw_rate     = wz;
        heading      = hd;
        frame_global = fg;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_word(c);
    endtask

    task automatic idle_input(input int cycles);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // drop valid and hold until every expected word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending_speeds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [0:0] idx,
                                  input logic [mik_pkg::ARM_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == mik_pkg::CFG_ROLLER_LAYOUT)
            sb.layout = value[0];
        else
            sb.arm = value;
    endtask

    function automatic logic signed [31:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return mik_pkg::WHEEL_MAX;
            1:       return mik_pkg::WHEEL_MIN;
            2:       return 32'sd0;
            3, 4:    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            5:       return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [15:0] pick_heading();
        logic signed [15:0] h;
        case ($urandom_range(0, 7))
            0:       h = 16'sd0;
            1:       h = $urandom_range(0, 1) ? 16'sd6434 : 16'sd6433;
            2:       h = $urandom_range(0, 1) ? 16'sd12868 : 16'sd12867;
            3:       h = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
            default: h = $urandom;
        endcase
        if (($urandom_range(0, 1) == 1) && h != -16'sd32768)
            h = -h;
        return h;
    endfunction

    initial
    begin
        logic                      layout;
        logic [mik_pkg::ARM_W-1:0] arm;
        int                        burst_left;
        sb           = new();
        burst_left   = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = mik_pkg::CFG_ROLLER_LAYOUT;
        cfg_data     = '0;
        in_valid     = 1'b0;
        vel_x        = '0;
        vel_y        = '0;
        yaw_rate     = '0;
        heading      = '0;
        frame_global = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at reset settings
        send_cmd(32'sd0, 32'sd0, 32'sd0, 16'sd0, 1'b0);
        send_cmd(mik_pkg::WHEEL_MAX, 32'sd0, 32'sd0, 16'sd0, 1'b0);
        send_cmd(mik_pkg::WHEEL_MIN, 32'sd0, 32'sd0, 16'sd0, 1'b0);
        send_cmd(32'sd0, mik_pkg::WHEEL_MAX, 32'sd0, 16'sd0, 1'b0);
        send_cmd(32'sd0, mik_pkg::WHEEL_MIN, 32'sd0, 16'sd0, 1'b0);
        send_cmd(32'sd0, 32'sd0, mik_pkg::WHEEL_MAX, 16'sd0, 1'b0);
        send_cmd(32'sd0, 32'sd0, mik_pkg::WHEEL_MIN, 16'sd0, 1'b0);
        // wheel overflow in both directions
        send_cmd(mik_pkg::WHEEL_MAX, mik_pkg::WHEEL_MAX, mik_pkg::WHEEL_MAX, 16'sd0, 1'b0);
        send_cmd(mik_pkg::WHEEL_MIN, mik_pkg::WHEEL_MIN, mik_pkg::WHEEL_MIN, 16'sd0, 1'b0);
        // body frame ignores the heading
        send_cmd(32'sd65536, 32'sd131072, 32'sd0, 16'sd6434, 1'b0);
        send_cmd(32'sd65536, 32'sd131072, 32'sd32768, 16'sd0, 1'b1);
        // quarter and half turn fold boundaries
        send_cmd(32'sd65536, -32'sd65536, 32'sd4096, 16'sd6433, 1'b1);
        send_cmd(32'sd65536, -32'sd65536, 32'sd4096, 16'sd6434, 1'b1);
        send_cmd(32'sd65536, -32'sd65536, 32'sd4096, -16'sd6433, 1'b1);
        send_cmd(32'sd65536, -32'sd65536, 32'sd4096, -16'sd6434, 1'b1);
        send_cmd(32'sd200000, 32'sd70000, -32'sd9000, 16'sd12867, 1'b1);
        send_cmd(32'sd200000, 32'sd70000, -32'sd9000, -16'sd12868, 1'b1);
        // angle reduction past a half turn
        send_cmd(32'sd300000, -32'sd123456, 32'sd0, 16'sd32767, 1'b1);
        send_cmd(32'sd300000, -32'sd123456, 32'sd0, -16'sd32768, 1'b1);
        // negating the most negative velocity
        send_cmd(mik_pkg::WHEEL_MIN, mik_pkg::WHEEL_MAX, 32'sd0, 16'sd12868, 1'b1);
        send_cmd(mik_pkg::WHEEL_MIN, mik_pkg::WHEEL_MIN, mik_pkg::WHEEL_MAX, -16'sd6434, 1'b1);
        send_cmd(mik_pkg::WHEEL_MAX, mik_pkg::WHEEL_MIN, mik_pkg::WHEEL_MIN, 16'sd20000, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    layout = mik_pkg::LAYOUT_X;
                    arm    = mik_pkg::LEVER_ARM_RESET;
                end
                1:
                begin
                    layout = mik_pkg::LAYOUT_X;
                    arm    = '0;
                end
                2:
                begin
                    layout = mik_pkg::LAYOUT_O;
                    arm    = '1;
                end
                3:
                begin
                    layout = mik_pkg::LAYOUT_X;
                    arm    = '1;
                end
                4:
                begin
                    layout = mik_pkg::LAYOUT_O;
                    arm    = $urandom_range(0, 24'hFF_FFFF);
                end
                default:
                begin
                    layout = mik_pkg::LAYOUT_X;
                    arm    = $urandom_range(0, 24'hFF_FFFF);
                end
            endcase
            wait_drained();
            write_register(mik_pkg::CFG_ROLLER_LAYOUT, {{(mik_pkg::ARM_W-1){1'b0}}, layout});
            write_register(mik_pkg::CFG_LEVER_ARM, arm);
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 3) != 0)
                        idle_input($urandom_range(1, 12));
                    burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
                end
                burst_left--;
                send_cmd(pick_speed(), pick_speed(), pick_speed(), pick_heading(),
                         ($urandom_range(0, 3) != 0));
            end
        end

        wait_drained();
        repeat (LATENCY + 8)
            @(posedge clk);
        if (sb.pending_speeds.size() != 0)
            sb.fails++;
        if (sb.fails == 0)
            $display("[mecanum_inverse_kinematics_unit] OK");
        else
            $display("[mecanum_inverse_kinematics_unit] ERROR");
        $finish;
    end

endmodule
